// ===== design/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, payload types and controller/datapath interface types
// for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int POOL_UNITS   = 65536;
    localparam int HEADER_UNITS = 2;
    localparam int UNIT_BYTES   = 16;
    localparam int MIN_UNITS    = HEADER_UNITS + 1;
    localparam int BYTE_SHIFT   = 4;
    localparam int HDR_BYTES    = HEADER_UNITS * UNIT_BYTES;
    localparam int POOL_BYTES   = POOL_UNITS * UNIT_BYTES;

    localparam int IDX_W  = 16;            // unit index
    localparam int UNIT_W = IDX_W + 1;     // unit index or the pool end
    localparam int LANES  = 32;            // map bits per memory row
    localparam int LANE_W = 5;
    localparam int ROWS   = POOL_UNITS / LANES;
    localparam int ROW_W  = IDX_W - LANE_W;
    localparam int SIZE_W = 21;
    localparam int ADDR_W = 20;
    localparam int USED_W = 21;
    localparam int SUM_W  = SIZE_W + 1;
    localparam int NEED_W = SUM_W - BYTE_SHIFT;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NONE    = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SIZE_W-1:0] size_bytes;
        logic              pointer_valid;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
        logic [USED_W-1:0] free_bytes;
        logic [USED_W-1:0] used_bytes;
    } rsp_t;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISPATCH, S_AL_FIRST, S_AL_CHK, S_AL_CLRB, S_AL_TAKE,
        S_LK_CHK, S_RS_CHK, S_FR_START, S_FR_NX, S_FR_MN, S_FR_PV, S_FR_PC,
        S_SF_STEP, S_SB_STEP, S_W_WR, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLEAR, CMD_LATCH, CMD_LOOKUP_RD, CMD_AL_INIT, CMD_AL_FIRST,
        CMD_AL_NEXT, CMD_SCAN_FWD, CMD_SF_STEP, CMD_SCAN_BACK, CMD_SB_STEP,
        CMD_W_RD, CMD_W_WR, CMD_FREE_MARK, CMD_TAKE, CMD_FIT, CMD_NOSPACE, CMD_OUT
    } cmd_op_t;

    typedef enum logic [1:0] {
        SRC_B, SRC_FB, SRC_FOUND, SRC_SPLIT
    } src_t;

    typedef enum logic [1:0] {
        WK_SET_HF, WK_CLR_F, WK_SET_F, WK_CLR_HF
    } wkind_t;

    typedef struct packed {
        cmd_op_t op;
        src_t    src;
        wkind_t  kind;
        logic    idle;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       size_zero;
        logic       ptr_valid;
        logic       addr_ok;
        logic       lookup_ok;
        logic       fits;
        logic       scan_done;
        logic       at_end;
        logic       fit;
        logic       split;
        logic       nx_free;
        logic       fb_zero;
        logic       found_free;
        logic       clr_last;
        logic       out_free;
        logic       in_valid;
    } stat_t;

endpackage

// ===== design/first_fit_block_allocator.sv =====
// Response time grows with the map rows read and, for an allocate, the blocks passed.
// Throughput: one request at a time; the worst case is a moving resize through
// minimum-size blocks, set by the single map read port.
// Reset: asynchronous; a clearing pass over all 2048 map rows rebuilds the maps
// before the first request beat is taken.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a 16-byte-unit pool with block split and merging.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffba_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ffba_pkg::rsp_t rsp
);

    ffba_pkg::cmd_t  cmd;
    ffba_pkg::stat_t st;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    ffba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== design/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for the allocator: clearing pass, request dispatch, first-fit
// walk, block split, free with merging of both neighbors.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  ffba_pkg::stat_t st,
    output ffba_pkg::cmd_t  cmd
);

    ffba_pkg::state_t state_reg, state_next;
    ffba_pkg::state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_CLR;
            ret_reg   <= ffba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        cmd.op     = ffba_pkg::CMD_NONE;
        cmd.src    = ffba_pkg::SRC_B;
        cmd.kind   = ffba_pkg::WK_SET_F;
        cmd.idle   = 1'b0;
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ffba_pkg::S_CLR:
            begin
                cmd.op = ffba_pkg::CMD_CLEAR;
                if (st.clr_last)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            ffba_pkg::S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (st.in_valid)
                begin
                    cmd.op     = ffba_pkg::CMD_LATCH;
                    state_next = ffba_pkg::S_DISPATCH;
                end
            end
            ffba_pkg::S_DISPATCH:
            begin
                state_next = ffba_pkg::S_DONE;
                case (st.op)
                    ffba_pkg::OP_ALLOC:
                    begin
                        if (!st.size_zero)
                        begin
                            cmd.op     = ffba_pkg::CMD_AL_INIT;
                            state_next = ffba_pkg::S_AL_FIRST;
                        end
                    end
                    ffba_pkg::OP_FREE:
                    begin
                        if (st.ptr_valid && st.addr_ok)
                        begin
                            cmd.op     = ffba_pkg::CMD_LOOKUP_RD;
                            state_next = ffba_pkg::S_LK_CHK;
                        end
                    end
                    ffba_pkg::OP_RESIZE:
                    begin
                        if (!st.ptr_valid)
                        begin
                            if (!st.size_zero)
                            begin
                                cmd.op     = ffba_pkg::CMD_AL_INIT;
                                state_next = ffba_pkg::S_AL_FIRST;
                            end
                        end
                        else if (st.addr_ok)
                        begin
                            cmd.op     = ffba_pkg::CMD_LOOKUP_RD;
                            state_next = ffba_pkg::S_LK_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = ffba_pkg::S_DONE;
                    end
                endcase
            end
            ffba_pkg::S_AL_FIRST:
            begin
                cmd.op     = ffba_pkg::CMD_AL_FIRST;
                ret_next   = ffba_pkg::S_AL_CHK;
                state_next = ffba_pkg::S_SF_STEP;
            end
            ffba_pkg::S_SF_STEP:
            begin
                cmd.op = ffba_pkg::CMD_SF_STEP;
                if (st.scan_done)
                begin
                    state_next = ret_reg;
                end
            end
            ffba_pkg::S_SB_STEP:
            begin
                cmd.op = ffba_pkg::CMD_SB_STEP;
                if (st.scan_done)
                begin
                    state_next = ret_reg;
                end
            end
            ffba_pkg::S_AL_CHK:
            begin
                if (st.fit)
                begin
                    cmd.op     = ffba_pkg::CMD_W_RD;
                    state_next = ffba_pkg::S_W_WR;
                    if (st.split)
                    begin
                        cmd.src  = ffba_pkg::SRC_SPLIT;
                        cmd.kind = ffba_pkg::WK_SET_HF;
                        ret_next = ffba_pkg::S_AL_CLRB;
                    end
                    else
                    begin
                        cmd.src  = ffba_pkg::SRC_B;
                        cmd.kind = ffba_pkg::WK_CLR_F;
                        ret_next = ffba_pkg::S_AL_TAKE;
                    end
                end
                else if (st.at_end)
                begin
                    cmd.op     = ffba_pkg::CMD_NOSPACE;
                    state_next = ffba_pkg::S_DONE;
                end
                else
                begin
                    cmd.op     = ffba_pkg::CMD_AL_NEXT;
                    cmd.src    = ffba_pkg::SRC_FOUND;
                    ret_next   = ffba_pkg::S_AL_CHK;
                    state_next = ffba_pkg::S_SF_STEP;
                end
            end
            ffba_pkg::S_AL_CLRB:
            begin
                cmd.op     = ffba_pkg::CMD_W_RD;
                cmd.src    = ffba_pkg::SRC_B;
                cmd.kind   = ffba_pkg::WK_CLR_F;
                ret_next   = ffba_pkg::S_AL_TAKE;
                state_next = ffba_pkg::S_W_WR;
            end
            ffba_pkg::S_AL_TAKE:
            begin
                cmd.op = ffba_pkg::CMD_TAKE;
                // A resize that moved releases its old block afterwards.
                if (st.op == ffba_pkg::OP_RESIZE && st.ptr_valid)
                begin
                    state_next = ffba_pkg::S_FR_START;
                end
                else
                begin
                    state_next = ffba_pkg::S_DONE;
                end
            end
            ffba_pkg::S_W_WR:
            begin
                cmd.op     = ffba_pkg::CMD_W_WR;
                state_next = ret_reg;
            end
            ffba_pkg::S_LK_CHK:
            begin
                if (!st.lookup_ok)
                begin
                    state_next = ffba_pkg::S_DONE;
                end
                else if (st.op == ffba_pkg::OP_FREE || st.size_zero)
                begin
                    state_next = ffba_pkg::S_FR_START;
                end
                else
                begin
                    cmd.op     = ffba_pkg::CMD_SCAN_FWD;
                    cmd.src    = ffba_pkg::SRC_FB;
                    ret_next   = ffba_pkg::S_RS_CHK;
                    state_next = ffba_pkg::S_SF_STEP;
                end
            end
            ffba_pkg::S_RS_CHK:
            begin
                if (st.fits)
                begin
                    cmd.op     = ffba_pkg::CMD_FIT;
                    state_next = ffba_pkg::S_DONE;
                end
                else
                begin
                    cmd.op     = ffba_pkg::CMD_AL_INIT;
                    state_next = ffba_pkg::S_AL_FIRST;
                end
            end
            ffba_pkg::S_FR_START:
            begin
                cmd.op     = ffba_pkg::CMD_SCAN_FWD;
                cmd.src    = ffba_pkg::SRC_FB;
                ret_next   = ffba_pkg::S_FR_NX;
                state_next = ffba_pkg::S_SF_STEP;
            end
            ffba_pkg::S_FR_NX:
            begin
                cmd.op     = ffba_pkg::CMD_FREE_MARK;
                cmd.src    = ffba_pkg::SRC_FB;
                cmd.kind   = ffba_pkg::WK_SET_F;
                ret_next   = ffba_pkg::S_FR_MN;
                state_next = ffba_pkg::S_W_WR;
            end
            ffba_pkg::S_FR_MN:
            begin
                if (st.nx_free)
                begin
                    cmd.op     = ffba_pkg::CMD_W_RD;
                    cmd.src    = ffba_pkg::SRC_FOUND;
                    cmd.kind   = ffba_pkg::WK_CLR_HF;
                    ret_next   = ffba_pkg::S_FR_PV;
                    state_next = ffba_pkg::S_W_WR;
                end
                else
                begin
                    state_next = ffba_pkg::S_FR_PV;
                end
            end
            ffba_pkg::S_FR_PV:
            begin
                if (st.fb_zero)
                begin
                    state_next = ffba_pkg::S_DONE;
                end
                else
                begin
                    cmd.op     = ffba_pkg::CMD_SCAN_BACK;
                    ret_next   = ffba_pkg::S_FR_PC;
                    state_next = ffba_pkg::S_SB_STEP;
                end
            end
            ffba_pkg::S_FR_PC:
            begin
                if (st.found_free)
                begin
                    cmd.op     = ffba_pkg::CMD_W_RD;
                    cmd.src    = ffba_pkg::SRC_FB;
                    cmd.kind   = ffba_pkg::WK_CLR_HF;
                    ret_next   = ffba_pkg::S_DONE;
                    state_next = ffba_pkg::S_W_WR;
                end
                else
                begin
                    state_next = ffba_pkg::S_DONE;
                end
            end
            ffba_pkg::S_DONE:
            begin
                cmd.op = ffba_pkg::CMD_OUT;
                if (st.out_free)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // Every map write outside the clearing pass is the second half of a read-modify-write.
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffba_pkg::S_W_WR |->
            $past(cmd.op == ffba_pkg::CMD_W_RD || cmd.op == ffba_pkg::CMD_FREE_MARK))
        else $error("map write without a preceding row read");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffba_pkg::S_CLR && !st.clr_last |=> state_reg == ffba_pkg::S_CLR)
        else $error("clearing pass left early");
`endif

endmodule

// ===== design/ffba_dp.sv =====
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: block maps in RAM (32 units per row, head and free bits), row
// scanners, read-modify-write of map bits, used-byte counter, result register.
// ----------------------------------------------------------------------------
module ffba_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  ffba_pkg::cmd_t cmd,
    output ffba_pkg::stat_t st,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffba_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ffba_pkg::rsp_t rsp
);

    localparam int LANES  = ffba_pkg::LANES;
    localparam int LANE_W = ffba_pkg::LANE_W;
    localparam int IDX_W  = ffba_pkg::IDX_W;
    localparam int UNIT_W = ffba_pkg::UNIT_W;
    localparam int ROW_W  = ffba_pkg::ROW_W;

    ffba_pkg::req_t              in_reg;
    logic [ffba_pkg::NEED_W-1:0] need_reg, need_calc;
    logic [ffba_pkg::NEED_W-1:0] need_raw;
    logic [IDX_W-1:0]            b_reg, fb_reg, wunit_reg;
    logic                        free_b_reg, found_free_reg, end_reg;
    logic [UNIT_W-1:0]           found_reg;
    logic [ROW_W-1:0]            row_reg, clr_cnt_reg;
    logic [LANES-1:0]            mask_reg;
    ffba_pkg::wkind_t            wkind_reg;
    logic [ffba_pkg::USED_W-1:0] used_reg, used_next;
    logic [ffba_pkg::ADDR_W-1:0] res_reg;
    ffba_pkg::status_t           st_reg;
    ffba_pkg::rsp_t              rsp_reg;
    logic                        rsp_valid_reg;

    logic                        ram_we, ram_re;
    logic [ROW_W-1:0]            ram_waddr, ram_raddr;
    logic [2*LANES-1:0]          ram_wdata, ram_rdata;

    logic [LANES-1:0]            head_bits, free_bits, hits, head_new, free_new;
    logic [LANE_W-1:0]           fwd_idx, back_idx, wlane;
    logic [IDX_W-1:0]            scan_p, q_back, wsel, blk_idx;
    logic [UNIT_W-1:0]           q_fwd, blk_wide, unit_wide;
    logic [UNIT_W-1:0]           len_b, len_fb, take_units;
    logic                        fit, split, at_end, scan_start, out_free, sf_last;
    logic [ffba_pkg::USED_W-1:0] free_out;

    ffba_ram #(
        .WIDTH (2 * LANES),
        .DEPTH (ffba_pkg::ROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign head_bits = ram_rdata[LANES-1:0];
    assign free_bits = ram_rdata[2*LANES-1:LANES];
    assign hits      = head_bits & mask_reg;
    assign sf_last   = (row_reg == ROW_W'(ffba_pkg::ROWS - 1));

    // Units needed: payload plus header, rounded up, never below the minimum.
    assign need_raw = ffba_pkg::NEED_W'((ffba_pkg::SUM_W'(req.size_bytes)
        + ffba_pkg::SUM_W'(ffba_pkg::HDR_BYTES + ffba_pkg::UNIT_BYTES - 1))
        >> ffba_pkg::BYTE_SHIFT);
    assign need_calc = (need_raw < ffba_pkg::NEED_W'(ffba_pkg::MIN_UNITS))
        ? ffba_pkg::NEED_W'(ffba_pkg::MIN_UNITS) : need_raw;

    assign unit_wide = UNIT_W'(in_reg.address >> ffba_pkg::BYTE_SHIFT);
    assign blk_wide  = unit_wide - UNIT_W'(ffba_pkg::HEADER_UNITS);
    assign blk_idx   = blk_wide[IDX_W-1:0];

    assign len_b      = found_reg - UNIT_W'(b_reg);
    assign len_fb     = found_reg - UNIT_W'(fb_reg);
    assign fit        = free_b_reg && (ffba_pkg::NEED_W'(len_b) >= need_reg);
    assign split      = (len_b - UNIT_W'(need_reg)) >= UNIT_W'(ffba_pkg::MIN_UNITS);
    assign take_units = split ? UNIT_W'(need_reg) : len_b;
    assign at_end     = (found_reg == UNIT_W'(ffba_pkg::POOL_UNITS));

    assign scan_start = (cmd.op == ffba_pkg::CMD_SCAN_FWD)
                     || (cmd.op == ffba_pkg::CMD_AL_FIRST)
                     || (cmd.op == ffba_pkg::CMD_AL_NEXT);

    always_comb
    begin
        case (cmd.src)
            ffba_pkg::SRC_B:     scan_p = b_reg;
            ffba_pkg::SRC_FB:    scan_p = fb_reg;
            ffba_pkg::SRC_FOUND: scan_p = found_reg[IDX_W-1:0];
            default:             scan_p = b_reg;
        endcase
        if (cmd.op == ffba_pkg::CMD_AL_FIRST)
        begin
            scan_p = '0;
        end
        case (cmd.src)
            ffba_pkg::SRC_B:     wsel = b_reg;
            ffba_pkg::SRC_FB:    wsel = fb_reg;
            ffba_pkg::SRC_FOUND: wsel = found_reg[IDX_W-1:0];
            default:             wsel = b_reg + IDX_W'(need_reg);
        endcase
    end

    assign q_fwd  = UNIT_W'(scan_p) + UNIT_W'(1);
    assign q_back = fb_reg - IDX_W'(1);

    // Lowest head for the forward walk, highest for the backward one.
    always_comb
    begin
        fwd_idx  = '0;
        back_idx = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                fwd_idx = LANE_W'(i);
            end
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (hits[i])
            begin
                back_idx = LANE_W'(i);
            end
        end
    end

    always_comb
    begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        case (cmd.op)
            ffba_pkg::CMD_AL_INIT:   ram_raddr = '0;
            ffba_pkg::CMD_LOOKUP_RD: ram_raddr = blk_idx[IDX_W-1:LANE_W];
            ffba_pkg::CMD_SCAN_FWD,
            ffba_pkg::CMD_AL_FIRST,
            ffba_pkg::CMD_AL_NEXT:   ram_raddr = q_fwd[IDX_W-1:LANE_W];
            ffba_pkg::CMD_SF_STEP:   ram_raddr = row_reg + ROW_W'(1);
            ffba_pkg::CMD_SCAN_BACK: ram_raddr = q_back[IDX_W-1:LANE_W];
            ffba_pkg::CMD_SB_STEP:   ram_raddr = row_reg - ROW_W'(1);
            ffba_pkg::CMD_W_RD,
            ffba_pkg::CMD_FREE_MARK: ram_raddr = wsel[IDX_W-1:LANE_W];
            default:                 ram_re = 1'b0;
        endcase
    end

    assign wlane = wunit_reg[LANE_W-1:0];

    always_comb
    begin
        head_new = head_bits;
        free_new = free_bits;
        case (wkind_reg)
            ffba_pkg::WK_SET_HF:
            begin
                head_new[wlane] = 1'b1;
                free_new[wlane] = 1'b1;
            end
            ffba_pkg::WK_CLR_F:
            begin
                free_new[wlane] = 1'b0;
            end
            ffba_pkg::WK_SET_F:
            begin
                free_new[wlane] = 1'b1;
            end
            default:
            begin
                head_new[wlane] = 1'b0;
                free_new[wlane] = 1'b0;
            end
        endcase
        ram_we    = 1'b0;
        ram_waddr = wunit_reg[IDX_W-1:LANE_W];
        ram_wdata = {free_new, head_new};
        if (cmd.op == ffba_pkg::CMD_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
            // Unit zero starts as one free block covering the pool.
            if (clr_cnt_reg == '0)
            begin
                ram_wdata[0]     = 1'b1;
                ram_wdata[LANES] = 1'b1;
            end
        end
        else if (cmd.op == ffba_pkg::CMD_W_WR)
        begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ffba_pkg::CMD_LATCH:
            begin
                in_reg   <= req;
                need_reg <= need_calc;
                st_reg   <= ffba_pkg::ST_NONE;
                res_reg  <= '0;
            end
            ffba_pkg::CMD_LOOKUP_RD:
            begin
                fb_reg <= blk_idx;
            end
            ffba_pkg::CMD_AL_INIT:
            begin
                b_reg <= '0;
            end
            ffba_pkg::CMD_AL_FIRST:
            begin
                free_b_reg <= free_bits[0];
            end
            ffba_pkg::CMD_AL_NEXT:
            begin
                b_reg      <= found_reg[IDX_W-1:0];
                free_b_reg <= found_free_reg;
            end
            ffba_pkg::CMD_SF_STEP:
            begin
                if (end_reg || (hits == '0 && sf_last))
                begin
                    found_reg      <= UNIT_W'(ffba_pkg::POOL_UNITS);
                    found_free_reg <= 1'b0;
                end
                else if (hits != '0)
                begin
                    found_reg      <= UNIT_W'({row_reg, fwd_idx});
                    found_free_reg <= free_bits[fwd_idx];
                end
                else
                begin
                    row_reg  <= row_reg + ROW_W'(1);
                    mask_reg <= '1;
                end
            end
            ffba_pkg::CMD_SCAN_BACK:
            begin
                row_reg  <= q_back[IDX_W-1:LANE_W];
                mask_reg <= ~(({LANES{1'b1}} << q_back[LANE_W-1:0]) << 1);
            end
            ffba_pkg::CMD_SB_STEP:
            begin
                if (hits != '0)
                begin
                    found_reg      <= UNIT_W'({row_reg, back_idx});
                    found_free_reg <= free_bits[back_idx];
                end
                else
                begin
                    row_reg  <= row_reg - ROW_W'(1);
                    mask_reg <= '1;
                end
            end
            ffba_pkg::CMD_W_RD,
            ffba_pkg::CMD_FREE_MARK:
            begin
                wunit_reg <= wsel;
                wkind_reg <= cmd.kind;
            end
            ffba_pkg::CMD_TAKE:
            begin
                res_reg <= ffba_pkg::ADDR_W'({UNIT_W'(b_reg)
                    + UNIT_W'(ffba_pkg::HEADER_UNITS), {ffba_pkg::BYTE_SHIFT{1'b0}}});
                st_reg  <= ffba_pkg::ST_OK;
            end
            ffba_pkg::CMD_FIT:
            begin
                res_reg <= in_reg.address;
                st_reg  <= ffba_pkg::ST_OK;
            end
            ffba_pkg::CMD_NOSPACE:
            begin
                st_reg <= ffba_pkg::ST_NOSPACE;
            end
            ffba_pkg::CMD_OUT:
            begin
                if (out_free)
                begin
                    rsp_reg.result_address <= res_reg;
                    rsp_reg.status         <= st_reg;
                    rsp_reg.free_bytes     <= free_out;
                    rsp_reg.used_bytes     <= used_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (scan_start)
        begin
            row_reg  <= q_fwd[IDX_W-1:LANE_W];
            mask_reg <= {LANES{1'b1}} << q_fwd[LANE_W-1:0];
            end_reg  <= (q_fwd == UNIT_W'(ffba_pkg::POOL_UNITS));
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.op == ffba_pkg::CMD_TAKE)
        begin
            used_next = used_reg + ffba_pkg::USED_W'({take_units,
                {ffba_pkg::BYTE_SHIFT{1'b0}}});
        end
        else if (cmd.op == ffba_pkg::CMD_FREE_MARK)
        begin
            used_next = used_reg - ffba_pkg::USED_W'({len_fb,
                {ffba_pkg::BYTE_SHIFT{1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= ffba_pkg::USED_W'(ffba_pkg::HDR_BYTES);
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (cmd.op == ffba_pkg::CMD_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
            end
            if (cmd.op == ffba_pkg::CMD_OUT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign free_out  = (used_reg >= ffba_pkg::USED_W'(ffba_pkg::POOL_BYTES)) ? '0
                     : ffba_pkg::USED_W'(ffba_pkg::POOL_BYTES) - used_reg;
    assign req_stall = !cmd.idle;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        st.op         = in_reg.operation;
        st.size_zero  = (in_reg.size_bytes == '0);
        st.ptr_valid  = in_reg.pointer_valid;
        st.addr_ok    = (in_reg.address[ffba_pkg::BYTE_SHIFT-1:0] == '0)
                     && (unit_wide >= UNIT_W'(ffba_pkg::HEADER_UNITS))
                     && (blk_wide < UNIT_W'(ffba_pkg::POOL_UNITS));
        st.lookup_ok  = head_bits[fb_reg[LANE_W-1:0]] && !free_bits[fb_reg[LANE_W-1:0]];
        st.fits       = in_reg.size_bytes <= ffba_pkg::SIZE_W'({len_fb
                     - UNIT_W'(ffba_pkg::HEADER_UNITS), {ffba_pkg::BYTE_SHIFT{1'b0}}});
        st.scan_done  = (cmd.op == ffba_pkg::CMD_SF_STEP)
                     ? (end_reg || hits != '0 || sf_last)
                     : (hits != '0 || row_reg == '0);
        st.at_end     = at_end;
        st.fit        = fit;
        st.split      = split;
        st.nx_free    = !at_end && found_free_reg;
        st.fb_zero    = (fb_reg == '0);
        st.found_free = found_free_reg;
        st.clr_last   = (clr_cnt_reg == ROW_W'(ffba_pkg::ROWS - 1));
        st.out_free   = out_free;
        st.in_valid   = req_valid;
    end

`ifndef ASSERT_OFF
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg >= ffba_pkg::USED_W'(ffba_pkg::HDR_BYTES)
        && used_reg <= ffba_pkg::USED_W'(ffba_pkg::POOL_BYTES + ffba_pkg::HDR_BYTES))
        else $error("used byte count out of range");

    // Unit zero is always a head, so the backward walk stops at row zero.
    a_back_hits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == ffba_pkg::CMD_SB_STEP && row_reg == '0 |-> hits != '0)
        else $error("backward walk found no head in row zero");

    // The last block of the pool ends at the pool end, so only the fit is checked.
    a_take_fit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == ffba_pkg::CMD_TAKE |-> fit)
        else $error("block taken that does not fit");
`endif

endmodule

// ===== tb/first_fit_block_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Drives allocate, free, resize and no-op beats into the allocator, predicts each
// response from a local model of the block map and compares field by field.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;

    localparam int WATCHDOG_CYCLES = 400000;
    localparam int HOLD_CYCLES     = 3000;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    ffba_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    ffba_pkg::rsp_t rsp;

    first_fit_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Local copy of the pool layout.
    bit          head_map [ffba_pkg::POOL_UNITS];
    bit          free_map [ffba_pkg::POOL_UNITS];
    int unsigned used_sum;

    ffba_pkg::rsp_t pending_rsp [$];
    int unsigned    live_addrs [$];
    int             rsp_errors;
    int             table_errors;
    bit             hold_rsp;
    bit             valid_on;

    typedef struct {
        ffba_pkg::op_t     op;
        int unsigned       size;
        bit                pv;
        int unsigned       addr;
        bit                has_rsp;
        int unsigned       r_addr;
        ffba_pkg::status_t r_status;
    } vector_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned next_block(int unsigned b);
        int unsigned u;
        u = b + 1;
        while (u < ffba_pkg::POOL_UNITS && !head_map[u])
            u++;
        return u;
    endfunction

    function automatic int unsigned prev_block(int unsigned b);
        int unsigned u;
        u = b;
        while (u > 0)
        begin
            u--;
            if (head_map[u])
                return u;
        end
        return 0;
    endfunction

    function automatic ffba_pkg::status_t take_block(int unsigned size,
                                                     output int unsigned addr);
        int unsigned need;
        int unsigned b;
        int unsigned nx;
        int unsigned len;
        addr = 0;
        if (size == 0)
            return ffba_pkg::ST_NONE;
        need = (size + ffba_pkg::HDR_BYTES + ffba_pkg::UNIT_BYTES - 1) / ffba_pkg::UNIT_BYTES;
        if (need < ffba_pkg::MIN_UNITS)
            need = ffba_pkg::MIN_UNITS;
        b = 0;
        while (b < ffba_pkg::POOL_UNITS)
        begin
            nx  = next_block(b);
            len = nx - b;
            if (free_map[b] && len >= need)
            begin
                if (len - need >= ffba_pkg::MIN_UNITS)
                begin
                    head_map[b + need] = 1'b1;
                    free_map[b + need] = 1'b1;
                    len = need;
                end
                free_map[b] = 1'b0;
                used_sum += len * ffba_pkg::UNIT_BYTES;
                addr = (b + ffba_pkg::HEADER_UNITS) * ffba_pkg::UNIT_BYTES;
                return ffba_pkg::ST_OK;
            end
            b = nx;
        end
        return ffba_pkg::ST_NOSPACE;
    endfunction

    function automatic bit find_live(int unsigned addr, output int unsigned blk);
        int unsigned unit;
        blk = 0;
        if (addr % ffba_pkg::UNIT_BYTES != 0)
            return 1'b0;
        unit = addr / ffba_pkg::UNIT_BYTES;
        if (unit < ffba_pkg::HEADER_UNITS)
            return 1'b0;
        blk = unit - ffba_pkg::HEADER_UNITS;
        if (blk >= ffba_pkg::POOL_UNITS)
            return 1'b0;
        return head_map[blk] && !free_map[blk];
    endfunction

    function automatic void release_block(int unsigned b);
        int unsigned nx;
        int unsigned pv;
        nx = next_block(b);
        used_sum -= (nx - b) * ffba_pkg::UNIT_BYTES;
        free_map[b] = 1'b1;
        if (nx < ffba_pkg::POOL_UNITS && free_map[nx])
        begin
            head_map[nx] = 1'b0;
            free_map[nx] = 1'b0;
        end
        if (b > 0)
        begin
            pv = prev_block(b);
            if (free_map[pv])
            begin
                head_map[b] = 1'b0;
                free_map[b] = 1'b0;
            end
        end
    endfunction

    function automatic void forget_addr(int unsigned a);
        foreach (live_addrs[i])
            if (live_addrs[i] == a)
            begin
                live_addrs.delete(i);
                return;
            end
    endfunction

    function automatic ffba_pkg::rsp_t predict_rsp(ffba_pkg::req_t r);
        ffba_pkg::rsp_t    p;
        int unsigned       res;
        int unsigned       blk;
        int unsigned       len;
        ffba_pkg::status_t st;
        bit                placed;
        res    = 0;
        st     = ffba_pkg::ST_NONE;
        placed = 1'b0;
        case (r.operation)
            ffba_pkg::OP_ALLOC:
            begin
                st     = take_block(r.size_bytes, res);
                placed = 1'b1;
            end
            ffba_pkg::OP_FREE:
                if (r.pointer_valid && find_live(r.address, blk))
                begin
                    release_block(blk);
                    forget_addr(r.address);
                end
            ffba_pkg::OP_RESIZE:
                if (!r.pointer_valid)
                begin
                    st     = take_block(r.size_bytes, res);
                    placed = 1'b1;
                end
                else if (find_live(r.address, blk))
                begin
                    if (r.size_bytes == 0)
                    begin
                        release_block(blk);
                        forget_addr(r.address);
                    end
                    else
                    begin
                        len = next_block(blk) - blk;
                        if (r.size_bytes <= (len - ffba_pkg::HEADER_UNITS) * ffba_pkg::UNIT_BYTES)
                        begin
                            res = r.address;
                            st  = ffba_pkg::ST_OK;
                        end
                        else
                        begin
                            st     = take_block(r.size_bytes, res);
                            placed = 1'b1;
                            if (st == ffba_pkg::ST_OK)
                            begin
                                release_block(blk);
                                forget_addr(r.address);
                            end
                        end
                    end
                end
            default:
                st = ffba_pkg::ST_NONE;
        endcase
        if (st == ffba_pkg::ST_OK && placed)
            live_addrs.push_back(res);
        if (st != ffba_pkg::ST_OK)
            res = 0;
        p.result_address = res[ffba_pkg::ADDR_W-1:0];
        p.status         = st;
        p.free_bytes     = (used_sum >= ffba_pkg::POOL_BYTES) ? '0
                         : ffba_pkg::USED_W'(ffba_pkg::POOL_BYTES - used_sum);
        p.used_bytes     = ffba_pkg::USED_W'(used_sum);
        return p;
    endfunction

    // Sends one beat and queues its prediction; a typed response is checked
    // against the prediction when given. Valid stays high after the accepting
    // edge only when the next beat follows with no gap.
    task automatic send_req(ffba_pkg::req_t r, bit has_rsp, int unsigned r_addr,
                            ffba_pkg::status_t r_st);
        ffba_pkg::rsp_t p;
        int             gap;
        gap = $urandom_range(0, 16);
        if (gap > 0)
        begin
            if (valid_on)
            begin
                req_valid <= 1'b0;
                valid_on  = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        valid_on  = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        p = predict_rsp(r);
        if (has_rsp)
        begin
            if (p.result_address != r_addr[ffba_pkg::ADDR_W-1:0])
            begin
                $error("result_address exp %0d got %0d", r_addr, p.result_address);
                table_errors++;
            end
            if (p.status != r_st)
            begin
                $error("status exp %0d got %0d", r_st, p.status);
                table_errors++;
            end
        end
        pending_rsp.push_back(p);
    endtask

    function automatic ffba_pkg::req_t make_req(ffba_pkg::op_t op, int unsigned size, bit pv,
                                                int unsigned addr);
        ffba_pkg::req_t r;
        r.operation     = op;
        r.size_bytes    = size[ffba_pkg::SIZE_W-1:0];
        r.pointer_valid = pv;
        r.address       = addr[ffba_pkg::ADDR_W-1:0];
        return r;
    endfunction

    function automatic ffba_pkg::req_t random_req();
        int unsigned   k;
        int unsigned   size;
        int unsigned   addr;
        bit            pv;
        ffba_pkg::op_t op;
        k    = $urandom_range(0, 99);
        size = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2097151) :
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 20000);
        pv   = 1'b1;
        addr = $urandom_range(0, 1048575);
        if (live_addrs.size() > 0 && $urandom_range(0, 9) != 0)
            addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        if (k < 45)
            op = ffba_pkg::OP_ALLOC;
        else if (k < 75)
            op = ffba_pkg::OP_FREE;
        else if (k < 95)
            op = ffba_pkg::OP_RESIZE;
        else
            op = ffba_pkg::OP_NONE;
        if ($urandom_range(0, 19) == 0)
            pv = 1'b0;
        return make_req(op, size, pv, addr);
    endfunction

    task automatic wait_drained();
        if (valid_on)
        begin
            req_valid <= 1'b0;
            valid_on  = 1'b0;
        end
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Response checking.
    always @(posedge clk)
    begin
        ffba_pkg::rsp_t exp_rsp;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response beat with nothing pending");
                rsp_errors++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp.result_address !== exp_rsp.result_address)
                begin
                    $error("result_address exp %0d got %0d", exp_rsp.result_address,
                           rsp.result_address);
                    rsp_errors++;
                end
                if (rsp.status !== exp_rsp.status)
                begin
                    $error("status exp %0d got %0d", exp_rsp.status, rsp.status);
                    rsp_errors++;
                end
                if (rsp.free_bytes !== exp_rsp.free_bytes)
                begin
                    $error("free_bytes exp %0d got %0d", exp_rsp.free_bytes, rsp.free_bytes);
                    rsp_errors++;
                end
                if (rsp.used_bytes !== exp_rsp.used_bytes)
                begin
                    $error("used_bytes exp %0d got %0d", exp_rsp.used_bytes, rsp.used_bytes);
                    rsp_errors++;
                end
            end
        end
    end

    // Receiver stalls.
    initial
    begin
        int stall_left;
        rsp_stall  = 1'b1;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
                rsp_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (rsp_valid && !rsp_stall)
            begin
                // Stretches without stalls keep some runs back to back.
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                rsp_stall <= (stall_left > 0);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog over cycles without any accepted beat.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        vector_t        dir_vec [$];
        vector_t        v;
        ffba_pkg::req_t r;
        int unsigned    a;
        rsp_errors   = 0;
        table_errors = 0;
        hold_rsp     = 1'b0;
        valid_on     = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        for (int i = 0; i < ffba_pkg::POOL_UNITS; i++)
        begin
            head_map[i] = 1'b0;
            free_map[i] = 1'b0;
        end
        head_map[0] = 1'b1;
        free_map[0] = 1'b1;
        used_sum    = ffba_pkg::HDR_BYTES;

        // Directed rows: op, size, pointer_valid, address, typed?, addr, status.
        dir_vec.push_back('{ffba_pkg::OP_ALLOC,  0,       0, 0,       1, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_ALLOC,  1,       0, 0,       1, 32, ffba_pkg::ST_OK});
        dir_vec.push_back('{ffba_pkg::OP_ALLOC,  2097151, 1, 1048575, 1, 0,
                            ffba_pkg::ST_NOSPACE});
        dir_vec.push_back('{ffba_pkg::OP_FREE,   0,       0, 32,      1, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_FREE,   0,       1, 33,      1, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_FREE,   0,       1, 0,       1, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_FREE,   0,       1, 1048575, 1, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_RESIZE, 16,      1, 32,      1, 32, ffba_pkg::ST_OK});
        dir_vec.push_back('{ffba_pkg::OP_ALLOC,  100,     1, 0,       0, 0,  ffba_pkg::ST_OK});
        dir_vec.push_back('{ffba_pkg::OP_ALLOC,  48,      0, 0,       0, 0,  ffba_pkg::ST_OK});
        dir_vec.push_back('{ffba_pkg::OP_RESIZE, 500,     1, 32,      0, 0,  ffba_pkg::ST_OK});
        dir_vec.push_back('{ffba_pkg::OP_RESIZE, 4000000, 1, 80,      0, 0,  ffba_pkg::ST_OK});
        dir_vec.push_back('{ffba_pkg::OP_FREE,   0,       1, 80,      1, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_FREE,   0,       1, 80,      1, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_RESIZE, 64,      0, 0,       0, 0,  ffba_pkg::ST_OK});
        dir_vec.push_back('{ffba_pkg::OP_RESIZE, 0,       1, 32,      0, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_NONE,   1,       1, 32,      1, 0,  ffba_pkg::ST_NONE});
        dir_vec.push_back('{ffba_pkg::OP_ALLOC,  1048544, 1, 0,       0, 0,  ffba_pkg::ST_OK});
        dir_vec.push_back('{ffba_pkg::OP_ALLOC,  1048576, 0, 0,       1, 0,
                            ffba_pkg::ST_NOSPACE});
        dir_vec.push_back('{ffba_pkg::OP_RESIZE, 1048576, 0, 0,       1, 0,
                            ffba_pkg::ST_NOSPACE});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_vec[i])
        begin
            v = dir_vec[i];
            send_req(make_req(v.op, v.size, v.pv, v.addr), v.has_rsp, v.r_addr, v.r_status);
        end

        // Release every live block, then take the whole pool in one block.
        wait_drained();
        while (live_addrs.size() > 0)
        begin
            a = live_addrs.pop_front();
            send_req(make_req(ffba_pkg::OP_FREE, 0, 1, a), 1'b0, 0, ffba_pkg::ST_OK);
        end
        send_req(make_req(ffba_pkg::OP_ALLOC, 1048544, 1, 0), 1'b1, 32, ffba_pkg::ST_OK);
        send_req(make_req(ffba_pkg::OP_FREE, 0, 1, 32), 1'b1, 0, ffba_pkg::ST_NONE);

        for (int n = 0; n < 800; n++)
        begin
            if (n == 200)
            begin
                // Long receiver hold-off while requests keep coming.
                fork
                    begin
                        hold_rsp = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_rsp = 1'b0;
                    end
                join_none
            end
            if (n == 500)
                wait_drained();
            r = random_req();
            send_req(r, 1'b0, 0, ffba_pkg::ST_OK);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (rsp_errors == 0 && table_errors == 0 && pending_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
